### sv/rgb_to_hsv_converter_unit_assert.svh
// assertion macros for the rgb to hsv converter checks
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RHC_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("rgb to hsv converter check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RHC_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("rgb to hsv converter check failed");

`endif

### sv/rhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    localparam int CH_W  = 16;
    // hue divisor is 6*delta, three bits wider than a channel
    localparam int HUE_W = CH_W + 3;

    // multiple of delta added to the hue numerator
    localparam logic [1:0] K_ZERO = 2'd0;
    localparam logic [1:0] K_TWO  = 2'd1;
    localparam logic [1:0] K_FOUR = 2'd2;
    localparam logic [1:0] K_SIX  = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]        mx;
        logic [CH_W-1:0]        mn;
        logic signed [CH_W:0]   diff;
        logic [1:0]             kcode;
    } front_t;

    typedef struct packed {
        logic [CH_W-1:0]  sat_rem;
        logic [CH_W-1:0]  sat_low;
        logic [CH_W-1:0]  sat_div;
        logic [HUE_W-1:0] hue_rem;
        logic [HUE_W-1:0] hue_div;
        logic [CH_W-1:0]  hue_quo;
        logic [CH_W-1:0]  value;
    } cell_t;

endpackage

`default_nettype wire

### sv/rgb_to_hsv_converter_unit.sv
// pipeline: compare stage, prep stage and 16 division cells, each a register stage
// throughput: one pixel per cycle while out_ready is high; each of the 16 cells makes one quotient bit
// of saturation and hue, so the cell chain sets the latency
// stalls fill bubbles first; in_ready drops only when every stage holds a word
// reset: rst_n asynchronous active low clears all valid flags, payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [rhc_pkg::CH_W-1:0] red_in,
    input  wire logic [rhc_pkg::CH_W-1:0] green_in,
    input  wire logic [rhc_pkg::CH_W-1:0] blue_in,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [rhc_pkg::CH_W-1:0]      hue_out,
    output logic [rhc_pkg::CH_W-1:0]      saturation_out,
    output logic [rhc_pkg::CH_W-1:0]      value_out
);
    import rhc_pkg::*;

    logic   front_valid;
    logic   front_ready;
    front_t front_data;

    logic  cvalid [0:CH_W];
    logic  cready [0:CH_W];
    cell_t cdata  [0:CH_W];

    rhc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .red      (red_in),
        .green    (green_in),
        .blue     (blue_in),
        .dn_valid (front_valid),
        .dn_ready (front_ready),
        .dn_data  (front_data)
    );

    rhc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (cvalid[0]),
        .dn_ready (cready[0]),
        .dn_data  (cdata[0])
    );

    for (genvar i = 0; i < CH_W; i++)
    begin : g_cell
        rhc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cvalid[i]),
            .up_ready (cready[i]),
            .up_data  (cdata[i]),
            .dn_valid (cvalid[i+1]),
            .dn_ready (cready[i+1]),
            .dn_data  (cdata[i+1])
        );
    end

    // last cell register is the output word
    assign cready[CH_W]   = out_ready;
    assign out_valid      = cvalid[CH_W];
    assign hue_out        = cdata[CH_W].hue_quo;
    assign saturation_out = cdata[CH_W].sat_low;
    assign value_out      = cdata[CH_W].value;

endmodule

`default_nettype wire

### sv/rhc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rhc_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     up_valid,
    output logic                          up_ready,
    input  wire logic [rhc_pkg::CH_W-1:0] red,
    input  wire logic [rhc_pkg::CH_W-1:0] green,
    input  wire logic [rhc_pkg::CH_W-1:0] blue,
    output logic                          dn_valid,
    input  wire logic                     dn_ready,
    output rhc_pkg::front_t               dn_data
);
    import rhc_pkg::*;

    logic   valid_reg;
    front_t data_reg;
    front_t data_next;

    logic                 red_max;
    logic                 green_max;
    logic signed [CH_W:0] diff_gb;
    logic signed [CH_W:0] diff_br;
    logic signed [CH_W:0] diff_rg;
    logic [CH_W-1:0]      min_rg;

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = (green >= blue);
        diff_gb   = $signed({1'b0, green}) - $signed({1'b0, blue});
        diff_br   = $signed({1'b0, blue}) - $signed({1'b0, red});
        diff_rg   = $signed({1'b0, red}) - $signed({1'b0, green});
        min_rg    = (green < red) ? green : red;
        data_next.mn = (blue < min_rg) ? blue : min_rg;
        // ties go to red, then green
        priority if (red_max)
        begin
            data_next.mx    = red;
            data_next.diff  = diff_gb;
            data_next.kcode = diff_gb[CH_W] ? K_SIX : K_ZERO;
        end
        else if (green_max)
        begin
            data_next.mx    = green;
            data_next.diff  = diff_br;
            data_next.kcode = K_TWO;
        end
        else
        begin
            data_next.mx    = blue;
            data_next.diff  = diff_rg;
            data_next.kcode = K_FOUR;
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### sv/rhc_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module rhc_prep (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire rhc_pkg::front_t up_data,
    output logic              dn_valid,
    input  wire logic         dn_ready,
    output rhc_pkg::cell_t    dn_data
);
    import rhc_pkg::*;

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;

    logic [CH_W-1:0]          delta;
    logic [HUE_W-1:0]         six_delta;
    logic [HUE_W-1:0]         k_delta;
    logic signed [HUE_W:0]    numer;
    logic [2*CH_W-1:0]        sat_num;

    always_comb
    begin
        delta     = up_data.mx - up_data.mn;
        six_delta = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
        unique case (up_data.kcode)
            K_ZERO:  k_delta = '0;
            K_TWO:   k_delta = {2'b00, delta, 1'b0};
            K_FOUR:  k_delta = {1'b0, delta, 2'b00};
            K_SIX:   k_delta = six_delta;
            default: k_delta = '0;
        endcase
        // num + k*delta, always in [0, 6*delta)
        numer   = $signed({{(HUE_W-CH_W){up_data.diff[CH_W]}}, up_data.diff})
                + $signed({1'b0, k_delta});
        // delta * full scale
        sat_num = {delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, delta};

        data_next.sat_rem = sat_num[2*CH_W-1:CH_W];
        data_next.sat_low = sat_num[CH_W-1:0];
        // a zero divisor only meets a zero dividend, so divide by one instead
        data_next.sat_div = (up_data.mx == '0) ? {{(CH_W-1){1'b0}}, 1'b1} : up_data.mx;
        data_next.hue_rem = numer[HUE_W-1:0];
        data_next.hue_div = (delta == '0) ? {{(HUE_W-1){1'b0}}, 1'b1} : six_delta;
        data_next.hue_quo = '0;
        data_next.value   = up_data.mx;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### sv/rhc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one restoring division step for both saturation and hue
module rhc_cell (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire rhc_pkg::cell_t up_data,
    output logic              dn_valid,
    input  wire logic         dn_ready,
    output rhc_pkg::cell_t    dn_data
);
    import rhc_pkg::*;

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;

    logic [CH_W:0]   sat_sh;
    logic [CH_W:0]   sat_diff;
    logic            sat_ge;
    logic [HUE_W:0]  hue_sh;
    logic [HUE_W:0]  hue_diff;
    logic            hue_ge;

    always_comb
    begin
        // saturation: next dividend bit comes from the top of sat_low
        sat_sh   = {up_data.sat_rem, up_data.sat_low[CH_W-1]};
        sat_diff = sat_sh - {1'b0, up_data.sat_div};
        sat_ge   = !sat_diff[CH_W];
        // hue: low dividend bits are all zero
        hue_sh   = {up_data.hue_rem, 1'b0};
        hue_diff = hue_sh - {1'b0, up_data.hue_div};
        hue_ge   = !hue_diff[HUE_W];

        data_next         = up_data;
        data_next.sat_rem = sat_ge ? sat_diff[CH_W-1:0] : sat_sh[CH_W-1:0];
        data_next.sat_low = {up_data.sat_low[CH_W-2:0], sat_ge};
        data_next.hue_rem = hue_ge ? hue_diff[HUE_W-1:0] : hue_sh[HUE_W-1:0];
        data_next.hue_quo = {up_data.hue_quo[CH_W-2:0], hue_ge};
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### sv/rhc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_converter_unit_assert.svh"

module rhc_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic [rhc_pkg::CH_W-1:0] red_in,
    input wire logic [rhc_pkg::CH_W-1:0] green_in,
    input wire logic [rhc_pkg::CH_W-1:0] blue_in,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [rhc_pkg::CH_W-1:0] hue_out,
    input wire logic [rhc_pkg::CH_W-1:0] saturation_out,
    input wire logic [rhc_pkg::CH_W-1:0] value_out
);
    import rhc_pkg::*;

    logic in_seen;

    // any input activity, only to keep every port in use
    assign in_seen = in_valid && (red_in != '0 || green_in != '0 || blue_in != '0);

    // a stalled output word holds
    `RHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hue_out) && $stable(saturation_out) && $stable(value_out))
    // input stalls only when the whole chain is full and the output is blocked
    `RHC_ASSERT_NOW(a_ready_full, !in_ready, out_valid && !out_ready)
    // a black pixel has no saturation
    `RHC_ASSERT_NOW(a_black_sat, out_valid && value_out == '0, saturation_out == '0)
    // zero saturation means a grey pixel, whose hue is zero
    `RHC_ASSERT_NOW(a_grey_hue, out_valid && saturation_out == '0, hue_out == '0 || in_seen != in_seen)

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (.*);

`default_nettype wire
